// ===== sv/pit_pkg.sv =====
package pit_pkg;

   // Number of counters built by default, and the most the block supports
   localparam int PIT_NUM_COUNTERS = 3;
   localparam int PIT_MAX_COUNTERS = 3;

   // Stream beat widths
   localparam int PIT_REQ_WIDTH = 16;
   localparam int PIT_RSP_WIDTH = 16;

   // Item operations
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } pit_op_type;

   // Port numbers beyond the counter data ports
   localparam logic [2:0] PORT_CMD = 3'd3;
   localparam logic [2:0] PORT_SPK = 3'd4;

   // Counter select code that means read-back
   localparam logic [1:0] SEL_READBACK = 2'd3;

   // Access codes
   localparam logic [1:0] ACC_LATCH = 2'd0;
   localparam logic [1:0] ACC_LSB   = 2'd1;
   localparam logic [1:0] ACC_MSB   = 2'd2;
   localparam logic [1:0] ACC_BOTH  = 2'd3;

   // Operating modes
   localparam logic [2:0] MODE_RATE   = 3'd2;
   localparam logic [2:0] MODE_SQUARE = 3'd3;

   // Per-counter controls decoded from one beat
   typedef struct packed {
      logic tick;
      logic wr;
      logic rd;
      logic ctrl_word;
      logic latch_cnt;
      logic latch_sts;
      logic gate;
      logic gate_rise;
      logic gate_fall;
   } pit_ctrl_type;

   // Count loaded at the start of a period (rate mode) or a half period (square wave).
   // A reload of zero stands for 65536; a half period is never shorter than one tick.
   function automatic logic [15:0] pit_phase_count(input logic [2:0]  mode,
                                                   input logic [15:0] reload,
                                                   input logic        lvl);
      logic [16:0] r;
      logic [16:0] n;
      r = (reload == 16'd0) ? 17'h10000 : {1'b0, reload};
      n = lvl ? (r + {16'd0, r[0]}) : (r - {16'd0, r[0]});
      if (n < 17'd2) begin
         n = 17'd2;
      end
      return (mode == MODE_SQUARE) ? n[15:0] : reload;
   endfunction

endpackage

// ===== sv/pit_counter.sv =====
module pit_counter (
   input  logic                 clock,
   input  logic                 reset,
   input  pit_pkg::pit_ctrl_type ctrl,
   input  logic [7:0]           wdata,
   output logic [7:0]           rdata,
   output logic                 level_in
);
   import pit_pkg::*;

   logic [15:0] count_ff, count_in;
   logic [15:0] reload_ff, reload_in;
   logic [2:0]  mode_ff, mode_in;
   logic [1:0]  access_ff, access_in;
   logic        wr_high_ff, wr_high_in;
   logic        rd_high_ff, rd_high_in;
   logic [15:0] lcount_ff, lcount_in;
   logic        count_latched_ff, count_latched_in;
   logic [7:0]  lstatus_ff, lstatus_in;
   logic        status_latched_ff, status_latched_in;
   logic        level_ff;
   logic        pending_ff, pending_in;
   logic        running_ff, running_in;

   logic [7:0]  status;
   logic [15:0] read_val;
   logic [15:0] count_dec;
   logic        rd_hi;
   logic        rd_last;

   // Status byte as the read-back command latches it
   assign status    = {level_ff, pending_ff | ~running_ff, access_ff, mode_ff, 1'b0};
   assign read_val  = count_latched_ff ? lcount_ff : count_ff;
   assign count_dec = count_ff - 16'd1;

   // Next state for one beat; the two latch controls may come together
   always_comb begin
      count_in          = count_ff;
      reload_in         = reload_ff;
      mode_in           = mode_ff;
      access_in         = access_ff;
      wr_high_in        = wr_high_ff;
      rd_high_in        = rd_high_ff;
      lcount_in         = lcount_ff;
      count_latched_in  = count_latched_ff;
      lstatus_in        = lstatus_ff;
      status_latched_in = status_latched_ff;
      level_in          = level_ff;
      pending_in        = pending_ff;
      running_in        = running_ff;
      rdata             = 8'd0;
      rd_hi             = 1'b0;
      rd_last           = 1'b0;

      if (ctrl.tick && ctrl.gate) begin
         if (!running_ff) begin
            // first count after a control word or a gate restart
            if (pending_ff) begin
               level_in   = 1'b1;
               count_in   = pit_phase_count(mode_ff, reload_ff, 1'b1);
               running_in = 1'b1;
               pending_in = 1'b0;
            end
         end else if (mode_ff == MODE_SQUARE) begin
            if (count_ff == 16'd1 || count_ff == 16'd2) begin
               level_in   = ~level_ff;
               count_in   = pit_phase_count(mode_ff, reload_ff, ~level_ff);
               pending_in = 1'b0;
            end else begin
               count_in = count_ff - 16'd2;
            end
         end else begin
            // rate generator: low for the one tick before terminal count
            if (count_ff == 16'd1) begin
               level_in   = 1'b1;
               count_in   = reload_ff;
               pending_in = 1'b0;
            end else begin
               count_in = count_dec;
               if (count_dec == 16'd1) begin
                  level_in = 1'b0;
               end
            end
         end
      end else if (ctrl.ctrl_word) begin
         access_in         = wdata[5:4];
         mode_in           = wdata[3:1];
         wr_high_in        = 1'b0;
         rd_high_in        = 1'b0;
         count_latched_in  = 1'b0;
         status_latched_in = 1'b0;
         level_in          = 1'b1;
         running_in        = 1'b0;
         pending_in        = 1'b0;
      end else if (ctrl.latch_cnt || ctrl.latch_sts) begin
         // an existing latch is left alone
         if (ctrl.latch_cnt && !count_latched_ff) begin
            lcount_in        = count_ff;
            count_latched_in = 1'b1;
         end
         if (ctrl.latch_sts && !status_latched_ff) begin
            lstatus_in        = status;
            status_latched_in = 1'b1;
         end
      end else if (ctrl.wr) begin
         case (access_ff)
            ACC_LSB: begin
               reload_in  = {8'd0, wdata};
               pending_in = 1'b1;
            end
            ACC_MSB: begin
               reload_in  = {wdata, 8'd0};
               pending_in = 1'b1;
            end
            default: begin
               if (!wr_high_ff) begin
                  reload_in  = {reload_ff[15:8], wdata};
                  wr_high_in = 1'b1;
               end else begin
                  reload_in  = {wdata, reload_ff[7:0]};
                  wr_high_in = 1'b0;
                  pending_in = 1'b1;
               end
            end
         endcase
      end else if (ctrl.rd) begin
         if (status_latched_ff) begin
            status_latched_in = 1'b0;
            rdata             = lstatus_ff;
         end else begin
            case (access_ff)
               ACC_LSB: begin
                  rd_hi   = 1'b0;
                  rd_last = 1'b1;
               end
               ACC_MSB: begin
                  rd_hi   = 1'b1;
                  rd_last = 1'b1;
               end
               default: begin
                  rd_hi      = rd_high_ff;
                  rd_high_in = ~rd_high_ff;
                  rd_last    = rd_high_ff;
               end
            endcase
            if (rd_last) begin
               count_latched_in = 1'b0;
            end
            rdata = rd_hi ? read_val[15:8] : read_val[7:0];
         end
      end else if (ctrl.gate_fall) begin
         level_in = 1'b1;
      end else if (ctrl.gate_rise) begin
         // restart from the reload value on the next tick
         if (running_ff) begin
            running_in = 1'b0;
            pending_in = 1'b1;
         end
      end
   end

   // Counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff          <= 16'd0;
         reload_ff         <= 16'd0;
         mode_ff           <= MODE_RATE;
         access_ff         <= ACC_BOTH;
         wr_high_ff        <= 1'b0;
         rd_high_ff        <= 1'b0;
         lcount_ff         <= 16'd0;
         count_latched_ff  <= 1'b0;
         lstatus_ff        <= 8'd0;
         status_latched_ff <= 1'b0;
         level_ff          <= 1'b1;
         pending_ff        <= 1'b0;
         running_ff        <= 1'b0;
      end else begin
         count_ff          <= count_in;
         reload_ff         <= reload_in;
         mode_ff           <= mode_in;
         access_ff         <= access_in;
         wr_high_ff        <= wr_high_in;
         rd_high_ff        <= rd_high_in;
         lcount_ff         <= lcount_in;
         count_latched_ff  <= count_latched_in;
         lstatus_ff        <= lstatus_in;
         status_latched_ff <= status_latched_in;
         level_ff          <= level_in;
         pending_ff        <= pending_in;
         running_ff        <= running_in;
      end
   end

endmodule

// ===== sv/programmable_interval_timer.sv =====
// A result beat appears in the cycle after its request beat is taken.
// Throughput: one request beat per cycle while result beats are taken; the result
// register frees up in the same cycle its beat is taken, so both sides stream at full rate.
// Reset: synchronous, active high; all counters return to rate mode, LSB-then-MSB
// access, output high and stopped; the speaker control clears; no result pending.
module programmable_interval_timer #(
   parameter int NUM_COUNTERS = pit_pkg::PIT_NUM_COUNTERS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pit_pkg::PIT_REQ_WIDTH-1:0] req_tdata,  // op[1:0], port[4:2], write_data[12:5]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pit_pkg::PIT_RSP_WIDTH-1:0] rsp_tdata   // read_data[7:0], timer_irq[8],
                                                         // speaker_out[9]
);
   import pit_pkg::*;

   pit_op_type  op;
   logic [2:0]  port;
   logic [7:0]  wd;
   logic        accept;
   logic        cmd_wr;
   logic        spk_wr;

   logic [1:0]  spk_ff, spk_in;
   logic        rsp_valid_ff;
   logic [PIT_RSP_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic [7:0]  cnt_rdata [PIT_MAX_COUNTERS];
   logic        cnt_level [PIT_MAX_COUNTERS];
   logic [7:0]  read_data;
   logic        speaker_out;

   assign op     = pit_op_type'(req_tdata[1:0]);
   assign port   = req_tdata[4:2];
   assign wd     = req_tdata[12:5];
   assign accept = req_tvalid && req_tready;
   assign cmd_wr = accept && (op == OP_WRITE) && (port == PORT_CMD);
   assign spk_wr = accept && (op == OP_WRITE) && (port == PORT_SPK);

   // Take a beat whenever the result register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;

   // Counters and their beat decode
   genvar i;
   generate
      for (i = 0; i < PIT_MAX_COUNTERS; i++) begin : g_cnt
         if (i < NUM_COUNTERS) begin : g_on
            pit_ctrl_type ctrl;
            logic         rb_sel;

            assign rb_sel = (wd[7:6] == SEL_READBACK) && wd[i+1];

            always_comb begin
               ctrl.tick      = accept && (op == OP_TICK);
               ctrl.wr        = accept && (op == OP_WRITE) && (port == 3'(i));
               ctrl.rd        = accept && (op == OP_READ) && (port == 3'(i));
               ctrl.ctrl_word = cmd_wr && (wd[7:6] == 2'(i)) && (wd[5:4] != ACC_LATCH);
               ctrl.latch_cnt = cmd_wr && (((wd[7:6] == 2'(i)) && (wd[5:4] == ACC_LATCH))
                                           || (rb_sel && !wd[5]));
               ctrl.latch_sts = cmd_wr && rb_sel && !wd[4];
               if (i == 2) begin
                  ctrl.gate      = spk_ff[0];
                  ctrl.gate_rise = spk_wr && !spk_ff[0] && wd[0];
                  ctrl.gate_fall = spk_wr && spk_ff[0] && !wd[0];
               end else begin
                  ctrl.gate      = 1'b1;
                  ctrl.gate_rise = 1'b0;
                  ctrl.gate_fall = 1'b0;
               end
            end

            pit_counter u_cnt (
               .clock    (clock),
               .reset    (reset),
               .ctrl     (ctrl),
               .wdata    (wd),
               .rdata    (cnt_rdata[i]),
               .level_in (cnt_level[i])
            );
         end else begin : g_off
            assign cnt_rdata[i] = 8'd0;
            assign cnt_level[i] = 1'b0;
         end
      end
   endgenerate

   // Speaker control register
   assign spk_in = spk_wr ? wd[1:0] : spk_ff;

   // Read data select
   always_comb begin
      read_data = 8'd0;
      if (op == OP_READ) begin
         if (port < 3'(NUM_COUNTERS)) begin
            read_data = cnt_rdata[port[1:0]];
         end else if (port == PORT_SPK) begin
            read_data = {6'd0, spk_ff};
         end
      end
   end

   assign speaker_out = (NUM_COUNTERS > 2) ? (cnt_level[2] & spk_in[1]) : 1'b0;
   assign rsp_data_in = {6'd0, speaker_out, cnt_level[0], read_data};

   // Result register and speaker state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         spk_ff       <= 2'd0;
      end else begin
         spk_ff <= spk_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An accepted beat always yields a result beat on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted beat produced no result");

   // No beat is taken while a result is stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !accept)
      else $error("result overwritten while stalled");

   // Speaker output never sounds with the enable bit clear
   a_spk_enable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[9]) |-> spk_ff[1])
      else $error("speaker driven while disabled");

endmodule
